>>> rtl/esc_pkg.sv
// shared types, constants and the divider step for the epipolar error scorer
// no dependencies; every other file of the block uses it, the rtl by scoped names, the bench by import
package esc_pkg;

  localparam int COORD_W   = 24;
  localparam int ENT_W     = 21;
  localparam int ROW_W     = 63;
  localparam int ERR_W     = 48;
  localparam int REM_W     = 62;
  localparam int DIV_STEPS = 48;
  localparam int FRONT_STAGES = 9;

  // metric modes, anything else scores as sampson
  localparam logic [1:0] MODE_ALG     = 2'd0;
  localparam logic [1:0] MODE_LINE    = 2'd1;
  localparam logic [1:0] MODE_SAMPSON = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_ROW0 = 2'd0;
  localparam logic [1:0] REG_ROW1 = 2'd1;
  localparam logic [1:0] REG_ROW2 = 2'd2;
  localparam logic [1:0] REG_MODE = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
  } esc_in_t;

  typedef struct packed {
    logic [ERR_W-1:0] error_value;
    logic             degenerate_flag;
  } esc_out_t;

  typedef struct packed {
    logic [ROW_W-1:0] row0;
    logic [ROW_W-1:0] row1;
    logic [ROW_W-1:0] row2;
    logic [1:0]       mode;
  } esc_cfg_t;

  // two long-division lanes plus the algebraic result riding along
  typedef struct packed {
    logic [REM_W-1:0] rem1;
    logic [REM_W-1:0] dvs1;
    logic [ERR_W-1:0] w1;
    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] dvs2;
    logic [ERR_W-1:0] w2;
    logic [ERR_W-1:0] alg;
    logic             alg_sat;
    logic             bad1;
    logic             bad2;
  } esc_div_t;

  // one restoring step: numerator bits leave the top of w, quotient bits enter below
  function automatic logic [REM_W+ERR_W-1:0] lane_step(input logic [REM_W-1:0] rem,
                                                      input logic [REM_W-1:0] dvs,
                                                      input logic [ERR_W-1:0] w);
    logic [REM_W:0] t;
    logic [REM_W:0] d;
    logic [REM_W:0] diff;
    t = {rem, w[ERR_W-1]};
    d = {1'b0, dvs};
    diff = t - d;
    if (t >= d) begin
      return {diff[REM_W-1:0], w[ERR_W-2:0], 1'b1};
    end
    return {t[REM_W-1:0], w[ERR_W-2:0], 1'b0};
  endfunction

  function automatic esc_div_t div_step(input esc_div_t s);
    esc_div_t o;
    o = s;
    {o.rem1, o.w1} = lane_step(s.rem1, s.dvs1, s.w1);
    {o.rem2, o.w2} = lane_step(s.rem2, s.dvs2, s.w2);
    return o;
  endfunction

endpackage

>>> rtl/esc_front.sv
// front datapath: epipolar lines, residual, its square and the denominators
// ends in the divider setup; depends on esc_pkg
module esc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  esc_pkg::esc_in_t  in_data,
  input  esc_pkg::esc_cfg_t cfg,
  output logic              div_valid,
  output esc_pkg::esc_div_t div_data
);

  function automatic logic signed [35:0] rnd11(input logic signed [46:0] v);
    logic signed [46:0] t;
    t = v + 47'sd1024;
    return t[46:11];
  endfunction

  function automatic logic signed [31:0] rnd15(input logic signed [46:0] v);
    logic signed [46:0] t;
    t = v + 47'sd16384;
    return t[46:15];
  endfunction

  logic [esc_pkg::FRONT_STAGES-1:0] v;
  logic [esc_pkg::ROW_W-1:0] rows [3];
  logic signed [esc_pkg::ENT_W-1:0] ent [3][3];

  // matrix entries
  assign rows[0] = cfg.row0;
  assign rows[1] = cfg.row1;
  assign rows[2] = cfg.row2;
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ent[r][c] = rows[r][c*esc_pkg::ENT_W +: esc_pkg::ENT_W];
      end
    end
  end

  // stage 1 products
  logic signed [44:0] pa0x, pa0y, pa1x, pa1y, pa2x, pa2y, pb0x, pb0y, pb1x, pb1y;
  logic signed [23:0] q1x1, q1y1;
  // stage 2 lines at scale 2^39
  logic signed [46:0] a0, a1, a2, b0, b1;
  logic signed [23:0] q1x2, q1y2;
  // stage 3 rounded lines
  logic signed [35:0] ar0, ar1, ar2;
  logic signed [31:0] va0, va1, vb0, vb1;
  logic signed [23:0] q1x3, q1y3;
  // stage 4 products and squares
  logic signed [59:0] m0, m1;
  logic signed [35:0] ar2_4;
  logic [61:0] sqa0, sqa1, sqb0, sqb1;
  logic signed [63:0] sqa0_w, sqa1_w, sqb0_w, sqb1_w;
  // stage 5 residual and denominators
  logic signed [61:0] r48;
  logic [61:0] dena5, denb5;
  // stage 6 absolute residual
  logic signed [61:0] r48_t;
  logic signed [45:0] r32;
  logic [45:0] abs_w;
  logic [42:0] ar;
  logic [61:0] dena6, denb6, dens6;
  // stage 7 partial products
  logic [63:0] ll;
  logic [42:0] lh;
  logic [21:0] hh;
  logic [61:0] dena7, denb7, dens7;
  // stage 8 squared residual at scale 2^64
  logic [85:0] n;
  logic [61:0] dena8, denb8, dens8;
  // stage 9 setup
  logic [61:0] d1;
  logic [53:0] nh;

  assign sqa0_w = 64'(va0) * 64'(va0);
  assign sqa1_w = 64'(va1) * 64'(va1);
  assign sqb0_w = 64'(vb0) * 64'(vb0);
  assign sqb1_w = 64'(vb1) * 64'(vb1);
  assign r48_t = r48 + 62'sd32768;
  assign r32 = r48_t[61:16];
  assign abs_w = r32[45] ? 46'(-r32) : 46'(r32);
  assign d1 = (cfg.mode == esc_pkg::MODE_LINE) ? denb8 : dens8;
  assign nh = n[85:32];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[esc_pkg::FRONT_STAGES-2:0], in_valid};
    end
  end
  assign div_valid = v[esc_pkg::FRONT_STAGES-1];

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      pa0x <= 45'(ent[0][0]) * 45'(in_data.second_x);
      pa0y <= 45'(ent[0][1]) * 45'(in_data.second_y);
      pa1x <= 45'(ent[1][0]) * 45'(in_data.second_x);
      pa1y <= 45'(ent[1][1]) * 45'(in_data.second_y);
      pa2x <= 45'(ent[2][0]) * 45'(in_data.second_x);
      pa2y <= 45'(ent[2][1]) * 45'(in_data.second_y);
      pb0x <= 45'(ent[0][0]) * 45'(in_data.first_x);
      pb0y <= 45'(ent[1][0]) * 45'(in_data.first_y);
      pb1x <= 45'(ent[0][1]) * 45'(in_data.first_x);
      pb1y <= 45'(ent[1][1]) * 45'(in_data.first_y);
      q1x1 <= in_data.first_x;
      q1y1 <= in_data.first_y;

      a0 <= 47'(pa0x) + 47'(pa0y) + (47'(ent[0][2]) <<< 20);
      a1 <= 47'(pa1x) + 47'(pa1y) + (47'(ent[1][2]) <<< 20);
      a2 <= 47'(pa2x) + 47'(pa2y) + (47'(ent[2][2]) <<< 20);
      b0 <= 47'(pb0x) + 47'(pb0y) + (47'(ent[2][0]) <<< 20);
      b1 <= 47'(pb1x) + 47'(pb1y) + (47'(ent[2][1]) <<< 20);
      q1x2 <= q1x1;
      q1y2 <= q1y1;

      ar0 <= rnd11(a0);
      ar1 <= rnd11(a1);
      ar2 <= rnd11(a2);
      va0 <= rnd15(a0);
      va1 <= rnd15(a1);
      vb0 <= rnd15(b0);
      vb1 <= rnd15(b1);
      q1x3 <= q1x2;
      q1y3 <= q1y2;

      m0 <= 60'(ar0) * 60'(q1x3);
      m1 <= 60'(ar1) * 60'(q1y3);
      ar2_4 <= ar2;
      sqa0 <= sqa0_w[61:0];
      sqa1 <= sqa1_w[61:0];
      sqb0 <= sqb0_w[61:0];
      sqb1 <= sqb1_w[61:0];

      r48 <= 62'(m0) + 62'(m1) + (62'(ar2_4) <<< 20);
      dena5 <= sqa0 + sqa1;
      denb5 <= sqb0 + sqb1;

      ar <= abs_w[42:0];
      dena6 <= dena5;
      denb6 <= denb5;
      dens6 <= dena5 + denb5;

      ll <= 64'(ar[31:0]) * 64'(ar[31:0]);
      lh <= 43'(ar[31:0]) * 43'(ar[42:32]);
      hh <= 22'(ar[42:32]) * 22'(ar[42:32]);
      dena7 <= dena6;
      denb7 <= denb6;
      dens7 <= dens6;

      n <= (86'(hh) << 64) + (86'(lh) << 33) + 86'(ll);
      dena8 <= dena7;
      denb8 <= denb7;
      dens8 <= dens7;

      // quotient reaches 2^48 exactly when the top of the numerator is not below the divisor
      div_data.rem1    <= 62'(nh);
      div_data.dvs1    <= d1;
      div_data.w1      <= {n[31:0], 16'd0};
      div_data.rem2    <= 62'(nh);
      div_data.dvs2    <= dena8;
      div_data.w2      <= {n[31:0], 16'd0};
      div_data.alg     <= n[79:32];
      div_data.alg_sat <= |n[85:80];
      div_data.bad1    <= (d1 == '0) || (62'(nh) >= d1);
      div_data.bad2    <= (dena8 == '0) || (62'(nh) >= dena8);
    end
  end

endmodule

>>> rtl/esc_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, two lanes side by side
// depends on esc_pkg
module esc_div_pipe (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  esc_pkg::esc_div_t in_data,
  output logic              out_valid,
  output esc_pkg::esc_div_t out_data
);

  logic [esc_pkg::DIV_STEPS-1:0] vs;
  esc_pkg::esc_div_t st [esc_pkg::DIV_STEPS];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (en) begin
      vs <= {vs[esc_pkg::DIV_STEPS-2:0], in_valid};
    end
  end

  // division steps
  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= esc_pkg::div_step(in_data);
      for (int k = 1; k < esc_pkg::DIV_STEPS; k++) begin
        st[k] <= esc_pkg::div_step(st[k-1]);
      end
    end
  end

  assign out_valid = vs[esc_pkg::DIV_STEPS-1];
  assign out_data  = st[esc_pkg::DIV_STEPS-1];

endmodule

>>> rtl/epipolar_error_scorer.sv
// epipolar error scorer top level: configuration registers, result select, output skid
// depends on esc_pkg, esc_front and esc_div_pipe
//
// Scores point correspondences against a 3x3 essential matrix.
// Channels: in_valid/in_ready/in_data carry one correspondence word per
// accept; out_valid/out_ready/out_data carry one error word per input, in
// order. cfg_valid/cfg_ready/cfg_index/cfg_data write the three matrix rows
// and the metric mode; cfg_ready is always high and writes are meant for
// idle periods only.
// Path from input accept to out_valid: 9 front stages
// (line products, rounding, residual square, denominators), 48 divider
// stages giving one quotient bit each, one result select stage and the
// output register.
// Throughput: one word per cycle while in_ready is high; the pipeline has no loop.
// Reset: rst clears all valid bits, matrix rows to zero, mode to Sampson.
// Receiver stall: the output register holds its word and one more word
// lands in the skid register; the whole pipeline then freezes and in_ready
// drops until the skid register drains.
module epipolar_error_scorer (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  esc_pkg::esc_in_t        in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output esc_pkg::esc_out_t       out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [esc_pkg::ROW_W-1:0] cfg_data
);

  esc_pkg::esc_cfg_t cfg;
  logic en;
  logic div_in_valid, div_out_valid;
  esc_pkg::esc_div_t div_in, div_out;
  logic fin_valid;
  esc_pkg::esc_out_t fin_data, fin_next;
  logic skid_valid;
  esc_pkg::esc_out_t skid_data;
  logic take;
  logic [esc_pkg::ERR_W:0] line_sum;

  assign cfg_ready = 1'b1;
  assign en        = !skid_valid;
  assign in_ready  = en;
  assign take      = out_ready || !out_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row0 <= '0;
      cfg.row1 <= '0;
      cfg.row2 <= '0;
      cfg.mode <= esc_pkg::MODE_SAMPSON;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        esc_pkg::REG_ROW0: cfg.row0 <= cfg_data;
        esc_pkg::REG_ROW1: cfg.row1 <= cfg_data;
        esc_pkg::REG_ROW2: cfg.row2 <= cfg_data;
        esc_pkg::REG_MODE: cfg.mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  esc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg       (cfg),
    .div_valid (div_in_valid),
    .div_data  (div_in)
  );

  esc_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_in_valid),
    .in_data   (div_in),
    .out_valid (div_out_valid),
    .out_data  (div_out)
  );

  // result select and saturation
  assign line_sum = {1'b0, div_out.w1} + {1'b0, div_out.w2};
  always_comb begin
    unique case (cfg.mode)
      esc_pkg::MODE_ALG: begin
        fin_next.error_value     = div_out.alg;
        fin_next.degenerate_flag = div_out.alg_sat;
      end
      esc_pkg::MODE_LINE: begin
        fin_next.error_value     = line_sum[esc_pkg::ERR_W-1:0];
        fin_next.degenerate_flag = div_out.bad1 || div_out.bad2 || line_sum[esc_pkg::ERR_W];
      end
      default: begin
        fin_next.error_value     = div_out.w1;
        fin_next.degenerate_flag = div_out.bad1;
      end
    endcase
    if (fin_next.degenerate_flag) begin
      fin_next.error_value = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (en) begin
      fin_valid <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_data <= fin_next;
    end
  end

  // output register and skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (fin_valid) begin
      if (take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_data <= skid_data;
      end
    end else if (fin_valid) begin
      if (take) begin
        out_data <= fin_data;
      end else begin
        skid_data <= fin_data;
      end
    end
  end

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held while output register empty");

  a_flag_saturates: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.degenerate_flag) |-> (out_data.error_value == '1))
    else $error("degenerate word without saturated error");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !skid_valid))
    else $error("words present right after reset");

endmodule

>>> bench/epipolar_error_scorer_tb.sv
// testbench for the epipolar error scorer: streams point pairs through phases of matrix and mode
// settings and checks every error word against an in-bench fixed-point scorer; uses esc_pkg
module epipolar_error_scorer_tb;
  import esc_pkg::*;

  localparam int LIMIT  = 400000;
  localparam int SETTLE = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  esc_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  esc_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_ROW0;
  logic [ROW_W-1:0] cfg_data = '0;

  epipolar_error_scorer DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // scorer copy of the configuration
  logic [ROW_W-1:0] m_row [3];
  logic [1:0] m_mode;

  esc_in_t pending_pairs[$];
  esc_out_t expected_errors[$];
  int send_idle = 0;
  int recv_idle = 0;
  int fails = 0;
  int accepted = 0;
  int cycles = 0;
  int hold_cnt = 0;
  bit hold_done = 0;
  bit in_took = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint entry(int r, int c);
    logic signed [ENT_W-1:0] f;
    longint v;
    f = m_row[r][ENT_W*c +: ENT_W];
    v = f;
    return v;
  endfunction

  // round half up at 2^s, floor semantics
  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [63:0] sq24(longint line39);
    longint v;
    v = round_shift(line39, 15);
    return v * v;
  endfunction

  // quotient floor(n * 2^16 / d) with saturation past 48 bits
  function automatic logic [63:0] quot(logic [127:0] n, logic [63:0] d, ref bit sat);
    logic [127:0] q;
    q = (n << 16) / {64'b0, d};
    if (q >= (128'd1 << 48)) begin
      sat = 1;
      return '1;
    end
    return q[63:0];
  endfunction

  function automatic esc_out_t score_pair(esc_in_t p);
    longint q1x, q1y, q2x, q2y, r48, r32;
    longint a [3];
    longint b [2];
    logic [63:0] ar, den_a, den_b, d1, d2, den;
    logic [127:0] n;
    logic [64:0] sum;
    logic [47:0] err;
    bit sat;
    esc_out_t o;
    q1x = p.first_x; q1y = p.first_y; q2x = p.second_x; q2y = p.second_y;
    sat = 0;
    err = '0;
    for (int i = 0; i < 3; i++)
      a[i] = entry(i, 0) * q2x + entry(i, 1) * q2y + entry(i, 2) * (longint'(1) <<< 20);
    for (int i = 0; i < 2; i++)
      b[i] = entry(0, i) * q1x + entry(1, i) * q1y + entry(2, i) * (longint'(1) <<< 20);
    r48 = round_shift(a[0], 11) * q1x + round_shift(a[1], 11) * q1y
        + round_shift(a[2], 11) * (longint'(1) <<< 20);
    r32 = round_shift(r48, 16);
    ar = (r32 < 0) ? -r32 : r32;
    n = {64'b0, ar} * {64'b0, ar};
    den_a = sq24(a[0]) + sq24(a[1]);
    den_b = sq24(b[0]) + sq24(b[1]);
    if (m_mode == MODE_ALG) begin
      if (n[127:80] != 0) sat = 1;
      else err = n[79:32];
    end else if (m_mode == MODE_LINE) begin
      if (den_a == 0 || den_b == 0) begin
        sat = 1;
      end else begin
        d1 = quot(n, den_b, sat);
        d2 = quot(n, den_a, sat);
        sum = {1'b0, d1} + {1'b0, d2};
        if (!sat) begin
          if (sum >= (65'd1 << 48)) sat = 1;
          else err = sum[47:0];
        end
      end
    end else begin
      den = den_a + den_b;
      if (den == 0) sat = 1;
      else err = quot(n, den, sat);
    end
    o.error_value = sat ? '1 : err;
    o.degenerate_flag = sat;
    return o;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    fails++;
  endtask

  // sampling at the rising edge: accepts, results, register writes, timeout
  always @(posedge clk) begin
    esc_out_t w;
    cycles++;
    if (cycles > LIMIT) begin
      $display("epipolar_error_scorer_tb failed");
      $finish;
    end
    in_took = 0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MODE) m_mode = cfg_data[1:0];
        else m_row[cfg_index] = cfg_data;
      end
      if (in_valid && in_ready) begin
        expected_errors.insert(expected_errors.size(), score_pair(in_data));
        accepted++;
        in_took = 1;
      end
      if (out_valid && out_ready) begin
        if (expected_errors.size() == 0) begin
          report("unexpected word", out_data.error_value, 0);
        end else begin
          w = expected_errors.pop_front();
          if (out_data.error_value !== w.error_value)
            report("error_value", out_data.error_value, w.error_value);
          if (out_data.degenerate_flag !== w.degenerate_flag)
            report("degenerate_flag", out_data.degenerate_flag, w.degenerate_flag);
        end
      end
    end
  end

  // input driver, fed from the pending queue
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_took)) begin
      if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_data <= pending_pairs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the pipeline fills and stalls its input
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && accepted >= 30) begin
      hold_cnt <= 400;
      hold_done <= 1;
    end
  end

  // result receiver
  always @(negedge clk) begin
    out_ready <= !rst && hold_cnt == 0 && $urandom_range(99) >= recv_idle;
  end

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(3))
      0: return COORD_W'($urandom_range(2**COORD_W - 1));
      1: return COORD_W'($urandom_range(2**18) - 2**17);
      2: return COORD_W'($urandom_range(2**21) - 2**20);
      default: begin
        case ($urandom_range(4))
          0: return 24'h7FFFFF;
          1: return 24'h800000;
          2: return 24'h000000;
          3: return 24'hFFFFFF;
          default: return 24'h000001;
        endcase
      end
    endcase
  endfunction

  function automatic logic [ENT_W-1:0] rand_entry(int kind);
    case (kind)
      0: return ENT_W'($urandom_range(2**ENT_W - 1));
      1: return ENT_W'($urandom_range(2**15) - 2**14);
      default: return ENT_W'($urandom_range(2**19) - 2**18);
    endcase
  endfunction

  task automatic write_regs(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1,
                            logic [ROW_W-1:0] r2, logic [1:0] mode);
    logic [ROW_W-1:0] vals [4];
    vals[0] = r0; vals[1] = r1; vals[2] = r2; vals[3] = {61'b0, mode};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || in_valid || expected_errors.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [ROW_W-1:0] rand_row(int kind);
    return {rand_entry(kind), rand_entry(kind), rand_entry(kind)};
  endfunction

  initial begin
    logic [ROW_W-1:0] r [3];
    logic [1:0] mode;
    esc_in_t p;
    logic [COORD_W-1:0] ext [5];
    ext[0] = 24'h7FFFFF; ext[1] = 24'h800000; ext[2] = 24'h0;
    ext[3] = 24'hFFFFFF; ext[4] = 24'h000001;
    m_row[0] = '0; m_row[1] = '0; m_row[2] = '0;
    m_mode = MODE_SAMPSON;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset matrix is zero: every pair has a zero denominator
    for (int i = 0; i < 4; i++) begin
      p = {rand_coord(), rand_coord(), rand_coord(), rand_coord()};
      pending_pairs.insert(pending_pairs.size(), p);
    end
    send_idle = 13; recv_idle = 73;
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 5) begin send_idle = 73; recv_idle = 13; end
      if (ph == 10) begin send_idle = 0; recv_idle = 0; end
      mode = 2'(ph % 4);
      case (ph)
        0: begin r[0] = {3{21'h0FFFFF}}; r[1] = r[0]; r[2] = r[0]; end
        1: begin r[0] = {3{21'h100000}}; r[1] = r[0]; r[2] = r[0]; end
        // columns zero except the last: the view-one line direction vanishes
        2, 6: begin
          r[0] = {rand_entry(0), 42'b0}; r[1] = {rand_entry(0), 42'b0};
          r[2] = {rand_entry(0), 42'b0};
        end
        default: for (int k = 0; k < 3; k++) r[k] = rand_row(ph % 3);
      endcase
      write_regs(r[0], r[1], r[2], mode);
      // extreme coordinate corners at the extreme matrices
      if (ph < 2) begin
        for (int i = 0; i < 10; i++) begin
          p.first_x = ext[i % 5]; p.first_y = ext[(i + 1) % 5];
          p.second_x = ext[(i + 2) % 5]; p.second_y = ext[(i * 3) % 5];
          pending_pairs.insert(pending_pairs.size(), p);
        end
      end
      for (int i = 0; i < 90; i++) begin
        p = {rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        pending_pairs.insert(pending_pairs.size(), p);
      end
      drain();
    end

    if (fails == 0) begin
      $display("epipolar_error_scorer_tb passed");
    end else begin
      $display("epipolar_error_scorer_tb failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/esc_pkg.sv
rtl/esc_front.sv
rtl/esc_div_pipe.sv
rtl/epipolar_error_scorer.sv
bench/epipolar_error_scorer_tb.sv
